>>> rtl/rc4fb_pkg.sv
// Shared types and constants for the feedback RC4 byte cipher.
`default_nettype none

package rc4fb_pkg;

  localparam int BOX_DEPTH = 256;
  localparam int BYTE_W = 8;
  localparam int CNT_W = $clog2(BOX_DEPTH) + 1;

  localparam logic ACTION_KEY = 1'b0;
  localparam logic ACTION_DATA = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [1:0] {
    ALU_INC = 2'd0,
    ALU_JS  = 2'd1,
    ALU_T   = 2'd2,
    ALU_FB  = 2'd3
  } alu_op_e;

  typedef struct packed {
    byte_t idx_i;
    byte_t idx_j;
    byte_t mem_byte;
    byte_t s_i;
    byte_t s_j;
    byte_t idx_b;
    byte_t fb;
  } alu_opnd_t;

  typedef struct packed {
    logic  valid;
    byte_t data;
  } result_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_LOAD = 8'b0000_0010,
    ST_RD_A = 8'b0000_0100,
    ST_RD_B = 8'b0000_1000,
    ST_WR_A = 8'b0001_0000,
    ST_WR_B = 8'b0010_0000,
    ST_RD_T = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_e;

endpackage

`default_nettype wire

>>> rtl/rc4fb_alu.sv
// Shared 8-bit index adder with operand selection.
`default_nettype none

module rc4fb_alu
  import rc4fb_pkg::*;
(
  input  alu_op_e   op_i,
  input  alu_opnd_t opnd_i,
  output byte_t     sum_o
);

  byte_t op_a;
  byte_t op_b;

  always_comb begin
    case (op_i)
      ALU_INC: begin
        op_a = opnd_i.idx_i;
        op_b = byte_t'(1);
      end
      ALU_JS: begin
        op_a = opnd_i.idx_j;
        op_b = opnd_i.mem_byte;
      end
      ALU_T: begin
        op_a = opnd_i.s_i;
        op_b = opnd_i.s_j;
      end
      ALU_FB: begin
        op_a = opnd_i.idx_b;
        op_b = opnd_i.fb;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign sum_o = op_a + op_b;

endmodule

`default_nettype wire

>>> rtl/rc4fb_core.sv
// Sequencer, key store and working box of the feedback RC4 cipher.
`default_nettype none

module rc4fb_core
  import rc4fb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_fire_i,
  input  logic    action_i,
  input  byte_t   key_index_i,
  input  byte_t   byte_in_i,
  input  logic    encrypt_i,
  input  logic    packet_start_i,
  input  logic    out_free_i,
  output logic    in_ready_o,
  output result_t res_o
);

  byte_t key_store [BOX_DEPTH];
  byte_t work_box [BOX_DEPTH];

  state_e state_q, state_d;
  byte_t idx_i_q, idx_i_d;
  byte_t idx_j_q, idx_j_d;
  logic [CNT_W-1:0] ld_cnt_q, ld_cnt_d;
  logic wr_pend_q, wr_pend_d;
  byte_t wr_addr_q;

  byte_t data_q;
  logic enc_q;
  byte_t a_q;
  byte_t b_q;
  byte_t si_q;
  byte_t sj_q;
  byte_t box_rdata_q;
  byte_t key_rdata_q;

  logic key_we;
  logic key_re;
  logic box_we;
  byte_t box_waddr;
  byte_t box_wdata;
  logic box_re;
  byte_t box_raddr;

  alu_op_e alu_op;
  alu_opnd_t alu_opnd;
  byte_t alu_sum;
  byte_t res_byte;

  rc4fb_alu u_alu (
    .op_i  (alu_op),
    .opnd_i(alu_opnd),
    .sum_o (alu_sum)
  );

  assign res_byte = data_q ^ box_rdata_q;
  assign in_ready_o = (state_q == ST_IDLE);
  assign key_we = in_fire_i && (action_i == ACTION_KEY);
  assign key_re = (state_q == ST_LOAD) && !ld_cnt_q[CNT_W-1];

  always_comb begin
    alu_opnd.idx_i = idx_i_q;
    alu_opnd.idx_j = idx_j_q;
    alu_opnd.mem_byte = box_rdata_q;
    alu_opnd.s_i = si_q;
    alu_opnd.s_j = sj_q;
    alu_opnd.idx_b = b_q;
    alu_opnd.fb = enc_q ? data_q : res_byte;
  end

  always_comb begin
    state_d = state_q;
    idx_i_d = idx_i_q;
    idx_j_d = idx_j_q;
    ld_cnt_d = ld_cnt_q;
    wr_pend_d = 1'b0;
    alu_op = ALU_INC;
    box_we = 1'b0;
    box_waddr = a_q;
    box_wdata = box_rdata_q;
    box_re = 1'b0;
    box_raddr = alu_sum;
    res_o.valid = 1'b0;
    res_o.data = res_byte;
    case (state_q)
      ST_IDLE: begin
        if (in_fire_i && (action_i == ACTION_DATA)) begin
          if (packet_start_i) begin
            state_d = ST_LOAD;
            ld_cnt_d = '0;
            idx_i_d = '0;
            idx_j_d = '0;
          end else begin
            state_d = ST_RD_A;
          end
        end
      end
      ST_LOAD: begin
        ld_cnt_d = ld_cnt_q + CNT_W'(1);
        wr_pend_d = !ld_cnt_q[CNT_W-1];
        box_we = wr_pend_q;
        box_waddr = wr_addr_q;
        box_wdata = key_rdata_q;
        if (ld_cnt_q[CNT_W-1]) begin
          state_d = ST_RD_A;
        end
      end
      ST_RD_A: begin
        alu_op = ALU_INC;
        box_re = 1'b1;
        state_d = ST_RD_B;
      end
      ST_RD_B: begin
        alu_op = ALU_JS;
        box_re = 1'b1;
        state_d = ST_WR_A;
      end
      ST_WR_A: begin
        box_we = 1'b1;
        box_waddr = a_q;
        box_wdata = box_rdata_q;
        state_d = ST_WR_B;
      end
      ST_WR_B: begin
        box_we = 1'b1;
        box_waddr = b_q;
        box_wdata = si_q;
        state_d = ST_RD_T;
      end
      ST_RD_T: begin
        alu_op = ALU_T;
        box_re = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        alu_op = ALU_FB;
        if (out_free_i) begin
          res_o.valid = 1'b1;
          idx_i_d = a_q;
          idx_j_d = alu_sum;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_i_q <= '0;
      idx_j_q <= '0;
      ld_cnt_q <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_i_q <= idx_i_d;
      idx_j_q <= idx_j_d;
      ld_cnt_q <= ld_cnt_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      data_q <= byte_in_i;
      enc_q <= encrypt_i;
    end
    wr_addr_q <= ld_cnt_q[CNT_W-2:0];
    if (state_q == ST_RD_A) begin
      a_q <= alu_sum;
    end
    if (state_q == ST_RD_B) begin
      si_q <= box_rdata_q;
      b_q <= alu_sum;
    end
    if (state_q == ST_WR_A) begin
      sj_q <= box_rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_store[key_index_i] <= byte_in_i;
    end
    if (key_re) begin
      key_rdata_q <= key_store[ld_cnt_q[CNT_W-2:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (box_we) begin
      work_box[box_waddr] <= box_wdata;
    end
    if (box_re) begin
      box_rdata_q <= work_box[box_raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/rc4_feedback_stream_cipher.sv
// Top level of the feedback RC4 byte cipher with its output register.
// A key byte write is one transfer and leaves the block ready for the next byte.
// A data byte goes from its transfer through the read, swap and keystream read on
// the working box, then waits for a free output register; ready returns once the result is handed over.
// A packet start first copies the key store into the working box.
// Reset clears the sequencer, both indices and the output valid; both stores hold
// undefined data until written.
`default_nettype none

module rc4_feedback_stream_cipher
  import rc4fb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  action_i,
  input  byte_t key_index_i,
  input  byte_t byte_in_i,
  input  logic  encrypt_i,
  input  logic  packet_start_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output byte_t byte_out_o
);

  logic in_fire;
  logic out_free;
  logic out_valid_q;
  byte_t byte_out_q;
  result_t res;

  assign in_fire = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  rc4fb_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .action_i      (action_i),
    .key_index_i   (key_index_i),
    .byte_in_i     (byte_in_i),
    .encrypt_i     (encrypt_i),
    .packet_start_i(packet_start_i),
    .out_free_i    (out_free),
    .in_ready_o    (in_ready_o),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      byte_out_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign byte_out_o = byte_out_q;

endmodule

`default_nettype wire

>>> rtl/rc4fb_checker.sv
// Port-level checks for the feedback RC4 cipher and their binding.
`default_nettype none

module rc4fb_checker
  import rc4fb_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_o,
  input logic  action_i,
  input logic  out_valid_o,
  input logic  out_ready_i,
  input byte_t byte_out_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (action_i == ACTION_DATA)) |=> !in_ready_o)
    else $error("Ready stayed high after a data byte transfer.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (action_i == ACTION_KEY)) |=> in_ready_o)
    else $error("Ready dropped after a key byte transfer.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("Result appeared while the block was idle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(byte_out_o)))
    else $error("Stalled result changed before its transfer.");

endmodule

bind rc4_feedback_stream_cipher rc4fb_checker u_rc4fb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .action_i   (action_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .byte_out_o (byte_out_o)
);

`default_nettype wire
